// File: rtl/core/rgbycc_pkg.sv
`default_nettype none

package rgbycc_pkg;

	// defaults for the top-level parameters
	localparam int COORD_BITS_DEF     = 12;
	localparam int COEF_FRAC_BITS_DEF = 16;

	// BT.601 full-range matrix, in thousandths
	localparam int Y_R_MILLI  = 299;
	localparam int Y_G_MILLI  = 587;
	localparam int Y_B_MILLI  = 114;
	localparam int CB_R_MILLI = -169;
	localparam int CB_G_MILLI = -331;
	localparam int CB_B_MILLI = 500;
	localparam int CR_R_MILLI = 500;
	localparam int CR_G_MILLI = -419;
	localparam int CR_B_MILLI = -81;

	// register indexes on the config port
	localparam logic REG_CHROMA_ORDER = 1'b0;
	localparam logic REG_PLANE_MASK   = 1'b1;

	localparam logic       CHROMA_ORDER_RST = 1'b0;
	localparam logic [3:0] PLANE_MASK_RST   = 4'hf;

	typedef struct packed {
		logic       chroma_order;
		logic [3:0] plane_mask;
	} cfg_t;

	// round(milli / 1000 * 2^frac), halves away from zero; elaboration only
	function automatic longint coef_fixed(input int milli, input int frac);
		longint mag;
		longint q;
		mag = (milli < 0) ? -longint'(milli) : longint'(milli);
		q   = ((mag << frac) + 64'sd500) / 64'sd1000;
		return (milli < 0) ? -q : q;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/rgbycc_row.sv
`default_nettype none

// One matrix row: three constant products, optional chroma offset, clamp.
module rgbycc_row #(
	parameter int M_R        = 0,
	parameter int M_G        = 0,
	parameter int M_B        = 0,
	parameter bit CHROMA     = 1'b0,
	parameter int FRAC_BITS  = rgbycc_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic      [7:0] code
);

	localparam int ACC_W = FRAC_BITS + 12;

	localparam logic signed [ACC_W-1:0] C_R =
		ACC_W'(rgbycc_pkg::coef_fixed(M_R, FRAC_BITS));
	localparam logic signed [ACC_W-1:0] C_G =
		ACC_W'(rgbycc_pkg::coef_fixed(M_G, FRAC_BITS));
	localparam logic signed [ACC_W-1:0] C_B =
		ACC_W'(rgbycc_pkg::coef_fixed(M_B, FRAC_BITS));
	localparam logic signed [ACC_W-1:0] OFFSET =
		CHROMA ? ACC_W'(longint'(255) << (FRAC_BITS - 1)) : '0;
	localparam logic signed [ACC_W-1:0] TOP = ACC_W'(longint'(255) << FRAC_BITS);

	logic signed [ACC_W-1:0] r_ext, g_ext, b_ext;
	logic signed [ACC_W-1:0] acc;

	assign r_ext = $signed({{(ACC_W-8){1'b0}}, red});
	assign g_ext = $signed({{(ACC_W-8){1'b0}}, green});
	assign b_ext = $signed({{(ACC_W-8){1'b0}}, blue});

	assign acc = C_R * r_ext + C_G * g_ext + C_B * b_ext + OFFSET;

	always_comb begin
		if (acc < 0) begin
			code = 8'd0;
		end else if (acc >= TOP) begin
			code = 8'd255;
		end else begin
			code = acc[FRAC_BITS+7:FRAC_BITS];	// floor
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rgb_to_ycbcr_pixel.sv
`default_nettype none

// RGBA to YCbCr converter, full-range BT.601, one pixel per clock.
//
// Input: a pixel beat (red, green, blue, alpha, pos_x, pos_y) is taken at
// a rising edge with start high and busy low. busy is always low, so a
// beat can come every cycle.
// Output: done is high for exactly one cycle per pixel, with plane0..3,
// plane_write_mask and out_x/out_y valid in that cycle. The receiver can
// not stall; results are never held.
// Pipeline: the beat lands in the input register at the accept
// edge, the matrix rows and clamps run in the next cycle and land in the
// result register, so done rises in the cycle after the input register loads.
// Throughput: 1 pixel per cycle, set by the single pass of constant
// multiplies between the two registers.
// Config: cfg_we/cfg_idx/cfg_wdata write chroma_order (index 0) or
// plane_mask (index 1) on any edge; change only while idle.
// Reset (arst_n low): pipeline empties, done low, chroma_order = 0,
// plane_mask = 4'hf.
module rgb_to_ycbcr_pixel #(
	parameter int COORD_BITS     = rgbycc_pkg::COORD_BITS_DEF,
	parameter int COEF_FRAC_BITS = rgbycc_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [7:0]            red,
	input  wire logic [7:0]            green,
	input  wire logic [7:0]            blue,
	input  wire logic [7:0]            alpha,
	input  wire logic [COORD_BITS-1:0] pos_x,
	input  wire logic [COORD_BITS-1:0] pos_y,

	output logic                       done,
	output logic [7:0]                 plane0,
	output logic [7:0]                 plane1,
	output logic [7:0]                 plane2,
	output logic [7:0]                 plane3,
	output logic [3:0]                 plane_write_mask,
	output logic [COORD_BITS-1:0]      out_x,
	output logic [COORD_BITS-1:0]      out_y,

	input  wire logic                  cfg_we,
	input  wire logic                  cfg_idx,
	input  wire logic [3:0]            cfg_wdata
);

	rgbycc_pkg::cfg_t cfg_q;

	logic                  accept;
	logic                  valid_s1;
	logic [7:0]            red_s1, green_s1, blue_s1, alpha_s1;
	logic [COORD_BITS-1:0] x_s1, y_s1;

	logic [7:0]            y_code, cb_code, cr_code;
	logic [7:0]            luma;
	logic [7:0]            p1_code, p2_code;
	logic                  p1_en, p2_en;
	logic [3:0]            wmask;

	logic                  valid_s2;

	// never stalls: the datapath is fully pipelined
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chroma_order <= rgbycc_pkg::CHROMA_ORDER_RST;
			cfg_q.plane_mask   <= rgbycc_pkg::PLANE_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				rgbycc_pkg::REG_CHROMA_ORDER: cfg_q.chroma_order <= cfg_wdata[0];
				rgbycc_pkg::REG_PLANE_MASK:   cfg_q.plane_mask   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			alpha_s1 <= alpha;
			x_s1     <= pos_x;
			y_s1     <= pos_y;
		end
	end

	// matrix rows
	rgbycc_row #(
		.M_R(rgbycc_pkg::Y_R_MILLI), .M_G(rgbycc_pkg::Y_G_MILLI),
		.M_B(rgbycc_pkg::Y_B_MILLI), .CHROMA(1'b0), .FRAC_BITS(COEF_FRAC_BITS)
	) u_row_y (
		.red(red_s1), .green(green_s1), .blue(blue_s1), .code(y_code)
	);

	rgbycc_row #(
		.M_R(rgbycc_pkg::CB_R_MILLI), .M_G(rgbycc_pkg::CB_G_MILLI),
		.M_B(rgbycc_pkg::CB_B_MILLI), .CHROMA(1'b1), .FRAC_BITS(COEF_FRAC_BITS)
	) u_row_cb (
		.red(red_s1), .green(green_s1), .blue(blue_s1), .code(cb_code)
	);

	rgbycc_row #(
		.M_R(rgbycc_pkg::CR_R_MILLI), .M_G(rgbycc_pkg::CR_G_MILLI),
		.M_B(rgbycc_pkg::CR_B_MILLI), .CHROMA(1'b1), .FRAC_BITS(COEF_FRAC_BITS)
	) u_row_cr (
		.red(red_s1), .green(green_s1), .blue(blue_s1), .code(cr_code)
	);

	// transparent pixel: luma forced to zero
	assign luma = (alpha_s1 == 8'd0) ? 8'd0 : y_code;

	// plane slots and write enables follow chroma order
	assign p1_code = cfg_q.chroma_order ? cr_code : cb_code;
	assign p2_code = cfg_q.chroma_order ? cb_code : cr_code;
	assign p1_en   = cfg_q.chroma_order ? cfg_q.plane_mask[2] : cfg_q.plane_mask[1];
	assign p2_en   = cfg_q.chroma_order ? cfg_q.plane_mask[1] : cfg_q.plane_mask[2];
	assign wmask   = {cfg_q.plane_mask[3], p2_en, p1_en, cfg_q.plane_mask[0]};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			plane0           <= wmask[0] ? luma     : 8'd0;
			plane1           <= wmask[1] ? p1_code  : 8'd0;
			plane2           <= wmask[2] ? p2_code  : 8'd0;
			plane3           <= wmask[3] ? alpha_s1 : 8'd0;
			plane_write_mask <= wmask;
			out_x            <= x_s1;
			out_y            <= y_s1;
		end
	end

	assign done = valid_s2;

endmodule

`default_nettype wire

// File: sim/rgb_to_ycbcr_pixel_tb.sv
`timescale 1ns / 1ps

// Pixel-stream check of the RGBA to YCbCr converter.
// Each accepted pixel beat is turned into an expected plane set by a local
// fixed-point model of the BT.601 matrix. Each done beat is then matched
// against the oldest expected set, field by field.
module rgb_to_ycbcr_pixel_tb;

	localparam int CRD_W        = rgbycc_pkg::COORD_BITS_DEF;
	localparam int FRAC         = rgbycc_pkg::COEF_FRAC_BITS_DEF;
	localparam int LIMIT_CYCLES = 100000;
	localparam int DRAIN_CYCLES = 6;     // pipeline is 2 deep, plus slack
	localparam int RAND_PER_SET = 80;
	localparam int NUM_SETS     = 6;     // register settings walked through
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [7:0]       r;
		logic [7:0]       g;
		logic [7:0]       b;
		logic [7:0]       a;
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
	} pixel_t;

	typedef struct packed {
		logic [7:0]       p0;
		logic [7:0]       p1;
		logic [7:0]       p2;
		logic [7:0]       p3;
		logic [3:0]       wmask;
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
	} planes_t;

	// Holds the register shadow, the matrix in Q.FRAC and the queue of
	// plane sets still owed by the block.
	class ycc_scoreboard;
		logic       chroma_swap;
		logic [3:0] enables;
		longint     weight[3][3];
		planes_t    owed[$];
		int         mismatches;

		function new();
			chroma_swap = rgbycc_pkg::CHROMA_ORDER_RST;
			enables     = rgbycc_pkg::PLANE_MASK_RST;
			mismatches  = 0;
			weight[0][0] = fixed_weight(rgbycc_pkg::Y_R_MILLI);
			weight[0][1] = fixed_weight(rgbycc_pkg::Y_G_MILLI);
			weight[0][2] = fixed_weight(rgbycc_pkg::Y_B_MILLI);
			weight[1][0] = fixed_weight(rgbycc_pkg::CB_R_MILLI);
			weight[1][1] = fixed_weight(rgbycc_pkg::CB_G_MILLI);
			weight[1][2] = fixed_weight(rgbycc_pkg::CB_B_MILLI);
			weight[2][0] = fixed_weight(rgbycc_pkg::CR_R_MILLI);
			weight[2][1] = fixed_weight(rgbycc_pkg::CR_G_MILLI);
			weight[2][2] = fixed_weight(rgbycc_pkg::CR_B_MILLI);
		endfunction

		// milli/1000 scaled to FRAC bits, ties go away from zero
		function longint fixed_weight(int milli);
			longint mag;
			longint q;
			mag = (milli < 0) ? -longint'(milli) : longint'(milli);
			q   = ((mag * (64'sd1 << FRAC)) + 64'sd500) / 64'sd1000;
			return (milli < 0) ? -q : q;
		endfunction

		// one matrix row; chroma rows carry the 127.5 code offset
		function logic [7:0] matrix_row(int row, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, bit chroma);
			longint acc;
			longint ceiling;
			acc = weight[row][0] * longint'(r) + weight[row][1] * longint'(g)
				+ weight[row][2] * longint'(b);
			ceiling = 64'sd255 <<< FRAC;
			if (chroma)
				acc += 64'sd255 <<< (FRAC - 1);
			if (acc < 0)
				return 8'd0;
			if (acc >= ceiling)
				return 8'd255;
			return 8'(acc >>> FRAC);
		endfunction

		function void write_reg(logic idx, logic [3:0] data);
			if (idx == rgbycc_pkg::REG_CHROMA_ORDER)
				chroma_swap = data[0];
			else
				enables = data;
		endfunction

		function void note_pixel(pixel_t px);
			logic [7:0] luma;
			logic [7:0] cb;
			logic [7:0] cr;
			logic       slot1_en;
			logic       slot2_en;
			planes_t    e;
			luma = matrix_row(0, px.r, px.g, px.b, 1'b0);
			cb   = matrix_row(1, px.r, px.g, px.b, 1'b1);
			cr   = matrix_row(2, px.r, px.g, px.b, 1'b1);
			if (px.a == 8'd0)
				luma = 8'd0;    // transparent pixel
			slot1_en = chroma_swap ? enables[2] : enables[1];
			slot2_en = chroma_swap ? enables[1] : enables[2];
			e.p0    = enables[0] ? luma : 8'd0;
			e.p1    = slot1_en ? (chroma_swap ? cr : cb) : 8'd0;
			e.p2    = slot2_en ? (chroma_swap ? cb : cr) : 8'd0;
			e.p3    = enables[3] ? px.a : 8'd0;
			e.wmask = {enables[3], slot2_en, slot1_en, enables[0]};
			e.x     = px.x;
			e.y     = px.y;
			owed.push_back(e);
		endfunction

		function void check_result(planes_t got);
			planes_t e;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: done beat with nothing owed: p0=%h p1=%h p2=%h p3=%h wm=%h x=%0d y=%0d",
						$realtime, got.p0, got.p1, got.p2, got.p3, got.wmask, got.x, got.y);
				return;
			end
			e = owed.pop_front();
			if (got.p0 !== e.p0 || got.p1 !== e.p1 || got.p2 !== e.p2
				|| got.p3 !== e.p3 || got.wmask !== e.wmask
				|| got.x !== e.x || got.y !== e.y) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: plane mismatch", $realtime);
					$display("  exp p0=%h p1=%h p2=%h p3=%h wm=%h x=%0d y=%0d",
						e.p0, e.p1, e.p2, e.p3, e.wmask, e.x, e.y);
					$display("  got p0=%h p1=%h p2=%h p3=%h wm=%h x=%0d y=%0d",
						got.p0, got.p1, got.p2, got.p3, got.wmask, got.x, got.y);
				end
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [7:0]       red;
	logic [7:0]       green;
	logic [7:0]       blue;
	logic [7:0]       alpha;
	logic [CRD_W-1:0] pos_x;
	logic [CRD_W-1:0] pos_y;
	logic             done;
	logic [7:0]       plane0;
	logic [7:0]       plane1;
	logic [7:0]       plane2;
	logic [7:0]       plane3;
	logic [3:0]       plane_write_mask;
	logic [CRD_W-1:0] out_x;
	logic [CRD_W-1:0] out_y;
	logic             cfg_we;
	logic             cfg_idx;
	logic [3:0]       cfg_wdata;

	ycc_scoreboard sb;
	int unsigned   cycles;
	bit            quiet;    // no sender gaps in the closing stretch

	rgb_to_ycbcr_pixel u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.alpha            (alpha),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.done             (done),
		.plane0           (plane0),
		.plane1           (plane1),
		.plane2           (plane2),
		.plane3           (plane3),
		.plane_write_mask (plane_write_mask),
		.out_x            (out_x),
		.out_y            (out_y),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog; a lost done beat ends up here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d beats still owed", cycles, sb.pending());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side cannot stall: every done beat is taken at the edge ending it.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result({plane0, plane1, plane2, plane3, plane_write_mask, out_x, out_y});
	end

	function automatic pixel_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic [7:0] a, logic [CRD_W-1:0] x, logic [CRD_W-1:0] y);
		pixel_t px;
		px.r = r;
		px.g = g;
		px.b = b;
		px.a = a;
		px.x = x;
		px.y = y;
		return px;
	endfunction

	// component code leaning on the rails so the clamps get hit often
	function automatic logic [7:0] rand_code();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t px;
		px.r = rand_code();
		px.g = rand_code();
		px.b = rand_code();
		px.a = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
		px.x = CRD_W'($urandom_range(0, (1 << CRD_W) - 1));
		px.y = CRD_W'($urandom_range(0, (1 << CRD_W) - 1));
		return px;
	endfunction

	// Called right after a rising edge. start stays high on return so that
	// back-to-back beats go out with no bubble.
	task automatic send_pixel(input pixel_t px);
		red   <= px.r;
		green <= px.g;
		blue  <= px.b;
		alpha <= px.a;
		pos_x <= px.x;
		pos_y <= px.y;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_pixel(px);
	endtask

	// random sender gap with start low, some of the time
	task automatic maybe_gap();
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 4);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// register writes only with the pipe empty
	task automatic wait_drained();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_directed();
		pixel_t list[$];
		list.push_back(mk_pixel(8'h00, 8'h00, 8'h00, 8'hff, '0, '0));          // black
		list.push_back(mk_pixel(8'hff, 8'hff, 8'hff, 8'hff, '1, '1));          // white
		list.push_back(mk_pixel(8'hff, 8'h00, 8'h00, 8'hff, '1, '0));          // Cr rail
		list.push_back(mk_pixel(8'h00, 8'hff, 8'h00, 8'hff, '0, '1));          // green
		list.push_back(mk_pixel(8'h00, 8'h00, 8'hff, 8'h80, 12'haaa, 12'h555)); // Cb rail
		list.push_back(mk_pixel(8'hff, 8'hff, 8'h00, 8'hff, 12'h555, 12'haaa)); // Cb floor
		list.push_back(mk_pixel(8'h00, 8'hff, 8'hff, 8'h01, 12'h001, 12'h800)); // Cr floor
		list.push_back(mk_pixel(8'hff, 8'h00, 8'hff, 8'hfe, 12'h800, 12'h001));
		list.push_back(mk_pixel(8'hff, 8'hff, 8'hff, 8'h00, 12'h123, 12'h456)); // transparent
		list.push_back(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00, 12'hfff, 12'h000));
		list.push_back(mk_pixel(8'h80, 8'h80, 8'h80, 8'h7f, 12'h7ff, 12'hfff)); // mid gray
		list.push_back(mk_pixel(8'h55, 8'haa, 8'h55, 8'haa, 12'h0f0, 12'hf0f));
		list.push_back(mk_pixel(8'haa, 8'h55, 8'haa, 8'h55, 12'hf0f, 12'h0f0));
		foreach (list[i])
			send_pixel(list[i]);
	endtask

	initial begin
		logic       order;
		logic [3:0] mask;
		sb        = new();
		cycles    = 0;
		quiet     = 1'b0;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		red       <= '0;
		green     <= '0;
		blue      <= '0;
		alpha     <= '0;
		pos_x     <= '0;
		pos_y     <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= rgbycc_pkg::REG_CHROMA_ORDER;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Setting 0 runs on reset values; later ones cover both orders, the all-off
		// mask and 4'h5 / 4'ha, then a random one, then default with no gaps.
		for (int s = 0; s < NUM_SETS; s++) begin
			if (s > 0) begin
				wait_drained();
				case (s)
					1: begin order = 1'b1; mask = 4'h0; end
					2: begin order = 1'b0; mask = 4'h5; end
					3: begin order = 1'b1; mask = 4'ha; end
					4: begin order = 1'($urandom_range(0, 1)); mask = 4'($urandom_range(0, 15)); end
					default: begin order = 1'b0; mask = 4'hf; end
				endcase
				// junk in the upper data bits: only bit 0 should stick
				write_reg(rgbycc_pkg::REG_CHROMA_ORDER, {3'($urandom_range(0, 7)), order});
				write_reg(rgbycc_pkg::REG_PLANE_MASK, mask);
				quiet = (s == NUM_SETS - 1);
			end
			if (s == 0)
				send_directed();
			if (s == 3)
				send_directed();    // swapped chroma with odd mask on the rails
			for (int i = 0; i < RAND_PER_SET; i++) begin
				send_pixel(rand_pixel());
				maybe_gap();
			end
		end

		wait_drained();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
